// ===== rtl/core/crg_pkg.sv =====
// ----------------------------------------------------------------------------
// crg_pkg
// Shared types and constants for the command replay gate.
// ----------------------------------------------------------------------------
package crg_pkg;

    localparam int CACHE_ENTRIES_DEF = 4;

    localparam int ID_W    = 8;
    localparam int SEQ_W   = 16;
    localparam int NONCE_W = 32;
    localparam int TIME_W  = 32;
    localparam int PARAM_W = 16;
    localparam int CFG_W   = 8;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 72;

    // configuration register indexes
    localparam logic CFG_DEPLOY_ID     = 1'b0;
    localparam logic CFG_DEPRECATED_ID = 1'b1;

    localparam logic [CFG_W-1:0] DEPLOY_ID_RST     = 8'd1;
    localparam logic [CFG_W-1:0] DEPRECATED_ID_RST = 8'd2;

    typedef enum logic [1:0] {
        STAGE_ACCEPTED  = 2'd0,
        STAGE_EXECUTED  = 2'd1,
        STAGE_REJECTED  = 2'd2,
        STAGE_DUPLICATE = 2'd3
    } ack_stage_t;

    typedef enum logic [2:0] {
        RES_OK            = 3'd0,
        RES_AUTH_FAILED   = 3'd1,
        RES_EXPIRED       = 3'd2,
        RES_ALREADY_DONE  = 3'd3,
        RES_BAD_FORMAT    = 3'd4,
        RES_NOT_SUPPORTED = 3'd5
    } ack_result_t;

    typedef enum logic [2:0] {
        RSN_NONE       = 3'd0,
        RSN_AUTH       = 3'd1,
        RSN_EXPIRED    = 3'd2,
        RSN_INHIBITED  = 3'd3,
        RSN_DEPRECATED = 3'd4,
        RSN_UNKNOWN    = 3'd5
    } reject_reason_t;

    // identity of one command instance, as held in the replay cache
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SEQ_W-1:0]   seq;
        logic [NONCE_W-1:0] nonce;
    } cmd_key_t;

    typedef struct packed {
        ack_stage_t     stage;
        ack_result_t    result;
        reject_reason_t reason;
        logic           fire;
    } ack_t;

endpackage

// ===== rtl/core/crg_replay_cache.sv =====
// ----------------------------------------------------------------------------
// crg_replay_cache
// Small fully associative cache of recent command keys, written round robin.
// ----------------------------------------------------------------------------
module crg_replay_cache #(
    parameter int ENTRIES = crg_pkg::CACHE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  crg_pkg::cmd_key_t lookup_key,
    output logic              hit,
    input  logic              write_en,
    input  crg_pkg::cmd_key_t write_key
);

    localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ENTRIES - 1);

    logic [ENTRIES-1:0] valid_reg;
    crg_pkg::cmd_key_t  key_reg [ENTRIES];
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_next;

    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_reg[i] && (key_reg[i] == lookup_key))
            begin
                hit = 1'b1;
            end
        end
    end

    assign ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end
        else if (write_en)
        begin
            valid_reg[ptr_reg] <= 1'b1;
            ptr_reg            <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            key_reg[ptr_reg] <= write_key;
        end
    end

endmodule

// ===== rtl/core/command_replay_gate.sv =====
// ----------------------------------------------------------------------------
// command_replay_gate
// Acknowledgement logic for one decoded uplink command with replay filtering.
// ----------------------------------------------------------------------------
// A command request is captured in an input register and judged from it
// against the authentication bit, the deadline, the replay cache and the
// two command id registers; the acks leave through an output register.
// Commands that give one ack are taken at one per cycle while m_tready is
// high, those that give none at one per cycle; a deploy gives an accepted
// ack and then an executed ack carrying the deploy strobe, so it holds the
// output register for both acks. The replay cache is a flip-flop array of
// CACHE_ENTRIES keys searched in parallel and starts empty after reset.
// Write the id registers only while no request is in flight.
module command_replay_gate #(
    parameter int CACHE_ENTRIES = crg_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // config write port
    input  logic                           cfg_we,
    input  logic                           cfg_addr,
    input  logic [crg_pkg::CFG_W-1:0]      cfg_wdata,
    // command requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // fields from bit 0: auth_ok, command_id, command_seq, nonce, deadline_ms,
    // now_ms, param_value, zero pad
    input  logic [crg_pkg::S_TDATA_W-1:0]  s_tdata,
    // fields: is_command
    input  logic [0:0]                     s_tuser,
    // acks
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // fields from bit 0: ack_stage, ack_result, reject_reason, echo_id,
    // echo_seq, echo_nonce, deploy_fire, zero pad
    output logic [crg_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);

    logic [crg_pkg::CFG_W-1:0] deploy_id_reg;
    logic [crg_pkg::CFG_W-1:0] deprecated_id_reg;

    // input register
    logic                        in_valid_reg;
    logic                        in_cmd_reg;
    logic                        in_auth_reg;
    crg_pkg::cmd_key_t           in_key_reg;
    logic [crg_pkg::TIME_W-1:0]  in_deadline_reg;
    logic [crg_pkg::TIME_W-1:0]  in_now_reg;
    logic [crg_pkg::PARAM_W-1:0] in_param_reg;

    // output register
    logic                        out_valid_reg;
    logic                        exec_pending_reg;
    crg_pkg::ack_t               ack_reg;
    crg_pkg::cmd_key_t           echo_reg;

    logic                        s_fire;
    logic                        out_free;
    logic                        eval_fire;
    logic                        ack_emit;
    logic                        hit;
    logic                        expired;
    logic [crg_pkg::TIME_W-1:0]  diff;
    logic                        two_acks;
    logic                        record;
    crg_pkg::ack_t               ack_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deploy_id_reg     <= crg_pkg::DEPLOY_ID_RST;
            deprecated_id_reg <= crg_pkg::DEPRECATED_ID_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == crg_pkg::CFG_DEPLOY_ID)
            begin
                deploy_id_reg <= cfg_wdata;
            end
            else
            begin
                deprecated_id_reg <= cfg_wdata;
            end
        end
    end

    // output slot frees when empty or when its final ack is taken now
    assign out_free  = !out_valid_reg || (m_tready && !exec_pending_reg);
    assign eval_fire = in_valid_reg && (out_free || !in_cmd_reg);
    assign ack_emit  = eval_fire && in_cmd_reg;
    assign s_tready  = !in_valid_reg || eval_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (eval_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_cmd_reg       <= s_tuser[0];
            in_auth_reg      <= s_tdata[0];
            in_key_reg.id    <= s_tdata[8:1];
            in_key_reg.seq   <= s_tdata[24:9];
            in_key_reg.nonce <= s_tdata[56:25];
            in_deadline_reg  <= s_tdata[88:57];
            in_now_reg       <= s_tdata[120:89];
            in_param_reg     <= s_tdata[136:121];
        end
    end

    crg_replay_cache #(
        .ENTRIES (CACHE_ENTRIES)
    ) u_cache (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_key (in_key_reg),
        .hit        (hit),
        .write_en   (ack_emit && record),
        .write_key  (in_key_reg)
    );

    // expired when now is after a nonzero deadline, by under half the wrap
    assign diff    = in_now_reg - in_deadline_reg;
    assign expired = (in_deadline_reg != '0) && (diff != '0) && !diff[crg_pkg::TIME_W-1];

    always_comb
    begin
        two_acks = 1'b0;
        record   = 1'b0;
        ack_next = '{crg_pkg::STAGE_REJECTED, crg_pkg::RES_NOT_SUPPORTED,
                     crg_pkg::RSN_UNKNOWN, 1'b0};
        if (!in_auth_reg)
        begin
            ack_next = '{crg_pkg::STAGE_REJECTED, crg_pkg::RES_AUTH_FAILED,
                         crg_pkg::RSN_AUTH, 1'b0};
        end
        else if (expired)
        begin
            ack_next = '{crg_pkg::STAGE_REJECTED, crg_pkg::RES_EXPIRED,
                         crg_pkg::RSN_EXPIRED, 1'b0};
        end
        else if (hit)
        begin
            ack_next = '{crg_pkg::STAGE_DUPLICATE, crg_pkg::RES_ALREADY_DONE,
                         crg_pkg::RSN_NONE, 1'b0};
        end
        else if (in_key_reg.id == deploy_id_reg)
        begin
            if (in_param_reg != '0)
            begin
                ack_next = '{crg_pkg::STAGE_REJECTED, crg_pkg::RES_BAD_FORMAT,
                             crg_pkg::RSN_INHIBITED, 1'b0};
            end
            else
            begin
                ack_next = '{crg_pkg::STAGE_ACCEPTED, crg_pkg::RES_OK,
                             crg_pkg::RSN_NONE, 1'b0};
                two_acks = 1'b1;
                record   = 1'b1;
            end
        end
        else if (in_key_reg.id == deprecated_id_reg)
        begin
            ack_next = '{crg_pkg::STAGE_REJECTED, crg_pkg::RES_NOT_SUPPORTED,
                         crg_pkg::RSN_DEPRECATED, 1'b0};
            record   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            exec_pending_reg <= 1'b0;
        end
        else if (ack_emit)
        begin
            out_valid_reg    <= 1'b1;
            exec_pending_reg <= two_acks;
        end
        else if (out_valid_reg && m_tready)
        begin
            out_valid_reg    <= exec_pending_reg;
            exec_pending_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ack_emit)
        begin
            ack_reg  <= ack_next;
            echo_reg <= in_key_reg;
        end
        else if (out_valid_reg && m_tready && exec_pending_reg)
        begin
            // second ack of a deploy carries the strobe
            ack_reg <= '{crg_pkg::STAGE_EXECUTED, crg_pkg::RES_OK, crg_pkg::RSN_NONE, 1'b1};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = !exec_pending_reg;
    assign m_tdata  = {7'd0, ack_reg.fire, echo_reg.nonce, echo_reg.seq, echo_reg.id,
                       ack_reg.reason, ack_reg.result, ack_reg.stage};

endmodule

// ===== bench/command_replay_gate_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_replay_gate_tb
// Self-checking bench for the command replay gate: a table of directed
// commands, then random phases under several id register settings, scored
// against typed rows' codes or an in-bench model of the ack rules and replay cache.
// ----------------------------------------------------------------------------
module command_replay_gate_tb;

    import crg_pkg::*;

    localparam int NUM_SLOTS     = CACHE_ENTRIES_DEF;
    localparam int DRAIN_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 150;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 155;
    localparam int NUM_PHASES    = 5;
    localparam int DIR_ROWS      = 23;

    typedef struct packed {
        logic               is_cmd;
        logic               auth;
        logic [ID_W-1:0]    id;
        logic [SEQ_W-1:0]   seq;
        logic [NONCE_W-1:0] nonce;
        logic [TIME_W-1:0]  deadline;
        logic [TIME_W-1:0]  now;
        logic [PARAM_W-1:0] param;
    } cmd_t;

    typedef struct packed {
        ack_stage_t         stage;
        ack_result_t        result;
        reject_reason_t     reason;
        logic [ID_W-1:0]    id;
        logic [SEQ_W-1:0]   seq;
        logic [NONCE_W-1:0] nonce;
        logic               fire;
        logic               is_last;
    } ack_exp_t;

    // typed rows carry their own ack count and codes
    typedef struct packed {
        cmd_t           c;
        logic           typed;
        logic [1:0]     n_acks;
        ack_stage_t     stage;
        ack_result_t    result;
        reject_reason_t reason;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_addr  = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // model state
    cmd_key_t             cache_key [NUM_SLOTS];
    bit                   cache_valid [NUM_SLOTS];
    int unsigned          cache_ptr;
    logic [ID_W-1:0]      deploy_id;
    logic [ID_W-1:0]      deprecated_id;

    ack_exp_t             pending_acks [$];
    cmd_key_t             recent_keys [$];

    bit                   steady;
    int                   hold_asks;
    int                   hold_taken;
    int                   hold_left;

    int                   errors;
    int                   requests_sent;
    int                   acks_checked;
    int                   fires_seen;
    int                   dups_seen;
    int                   id_settings;

    dir_row_t directed [DIR_ROWS] = '{
        // not a command: nothing comes back
        '{'{1'b0, 1'b1, 8'h01, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 16'h0},
          1'b1, 2'd0, STAGE_ACCEPTED, RES_OK, RSN_NONE},
        '{'{1'b1, 1'b0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            16'hFFFF}, 1'b1, 2'd1, STAGE_REJECTED, RES_AUTH_FAILED, RSN_AUTH},
        '{'{1'b1, 1'b0, 8'h00, 16'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b1, 2'd1, STAGE_REJECTED, RES_AUTH_FAILED, RSN_AUTH},
        // one ms past the deadline
        '{'{1'b1, 1'b1, 8'h10, 16'h1, 32'h1, 32'd100, 32'd101, 16'h0},
          1'b1, 2'd1, STAGE_REJECTED, RES_EXPIRED, RSN_EXPIRED},
        // deadline equal to now is still good
        '{'{1'b1, 1'b1, 8'h10, 16'h1, 32'h1, 32'd100, 32'd100, 16'h0},
          1'b1, 2'd1, STAGE_REJECTED, RES_NOT_SUPPORTED, RSN_UNKNOWN},
        '{'{1'b1, 1'b1, 8'hFF, 16'h2, 32'h2, 32'h0, 32'hFFFF_FFFF, 16'h0},
          1'b1, 2'd1, STAGE_REJECTED, RES_NOT_SUPPORTED, RSN_UNKNOWN},
        // lag of exactly half the range reads as future
        '{'{1'b1, 1'b1, 8'h20, 16'h3, 32'h3, 32'h1, 32'h8000_0001, 16'h0},
          1'b1, 2'd1, STAGE_REJECTED, RES_NOT_SUPPORTED, RSN_UNKNOWN},
        '{'{1'b1, 1'b1, 8'h20, 16'h4, 32'h4, 32'h1, 32'h8000_0000, 16'h0},
          1'b1, 2'd1, STAGE_REJECTED, RES_EXPIRED, RSN_EXPIRED},
        // deadline just before the time wraps
        '{'{1'b1, 1'b1, 8'h20, 16'h5, 32'h5, 32'hFFFF_FFFF, 32'h5, 16'h0},
          1'b1, 2'd1, STAGE_REJECTED, RES_EXPIRED, RSN_EXPIRED},
        '{'{1'b1, 1'b1, 8'h30, 16'h6, 32'h6, 32'h5, 32'hFFFF_FFF0, 16'h0},
          1'b1, 2'd1, STAGE_REJECTED, RES_NOT_SUPPORTED, RSN_UNKNOWN},
        // deploy with a parameter is inhibited
        '{'{1'b1, 1'b1, 8'h01, 16'h7, 32'h7, 32'h0, 32'h0, 16'h1234},
          1'b1, 2'd1, STAGE_REJECTED, RES_BAD_FORMAT, RSN_INHIBITED},
        '{'{1'b1, 1'b1, 8'h01, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'hFFFF},
          1'b1, 2'd1, STAGE_REJECTED, RES_BAD_FORMAT, RSN_INHIBITED},
        '{'{1'b1, 1'b1, 8'h01, 16'h0, 32'h0, 32'h0, 32'h1000, 16'h0},
          1'b0, 2'd0, STAGE_ACCEPTED, RES_OK, RSN_NONE},
        '{'{1'b1, 1'b1, 8'h01, 16'h0, 32'h0, 32'h0, 32'h1000, 16'h0},
          1'b1, 2'd1, STAGE_DUPLICATE, RES_ALREADY_DONE, RSN_NONE},
        '{'{1'b1, 1'b1, 8'h02, 16'h7, 32'h5A5A_0F0F, 32'h0, 32'h0, 16'h5},
          1'b1, 2'd1, STAGE_REJECTED, RES_NOT_SUPPORTED, RSN_DEPRECATED},
        '{'{1'b1, 1'b1, 8'h02, 16'h7, 32'h5A5A_0F0F, 32'h0, 32'h0, 16'h5},
          1'b1, 2'd1, STAGE_DUPLICATE, RES_ALREADY_DONE, RSN_NONE},
        // auth and deadline are judged ahead of the cache
        '{'{1'b1, 1'b0, 8'h01, 16'h0, 32'h0, 32'h0, 32'h1000, 16'h0},
          1'b1, 2'd1, STAGE_REJECTED, RES_AUTH_FAILED, RSN_AUTH},
        '{'{1'b1, 1'b1, 8'h01, 16'h0, 32'h0, 32'd10, 32'd20, 16'h0},
          1'b1, 2'd1, STAGE_REJECTED, RES_EXPIRED, RSN_EXPIRED},
        '{'{1'b0, 1'b1, 8'h01, 16'h0, 32'h0, 32'h0, 32'h1000, 16'h0},
          1'b1, 2'd0, STAGE_ACCEPTED, RES_OK, RSN_NONE},
        // fill the cache so the first deploy is evicted
        '{'{1'b1, 1'b1, 8'h01, 16'h1, 32'h11, 32'h0, 32'h0, 16'h0},
          1'b0, 2'd0, STAGE_ACCEPTED, RES_OK, RSN_NONE},
        '{'{1'b1, 1'b1, 8'h01, 16'h2, 32'h22, 32'h0, 32'h0, 16'h0},
          1'b0, 2'd0, STAGE_ACCEPTED, RES_OK, RSN_NONE},
        '{'{1'b1, 1'b1, 8'h01, 16'h3, 32'h33, 32'h0, 32'h0, 16'h0},
          1'b0, 2'd0, STAGE_ACCEPTED, RES_OK, RSN_NONE},
        '{'{1'b1, 1'b1, 8'h01, 16'h0, 32'h0, 32'h0, 32'h2000, 16'h0},
          1'b0, 2'd0, STAGE_ACCEPTED, RES_OK, RSN_NONE}
    };

    command_replay_gate #(
        .CACHE_ENTRIES (NUM_SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic ack_exp_t mk_ack(input ack_stage_t st, input ack_result_t rs,
                                        input reject_reason_t rn, input cmd_t c,
                                        input logic fire, input logic is_last);
        ack_exp_t a;
        a.stage   = st;
        a.result  = rs;
        a.reason  = rn;
        a.id      = c.id;
        a.seq     = c.seq;
        a.nonce   = c.nonce;
        a.fire    = fire;
        a.is_last = is_last;
        return a;
    endfunction

    // ack rules plus replay cache update; returns how many acks the command gives
    function automatic int judge_command(input cmd_t c, output ack_exp_t first,
                                         output ack_exp_t second);
        logic [TIME_W-1:0] lag;
        cmd_key_t          key;
        bit                seen;
        first  = '0;
        second = '0;
        if (!c.is_cmd)
            return 0;
        if (!c.auth)
        begin
            first = mk_ack(STAGE_REJECTED, RES_AUTH_FAILED, RSN_AUTH, c, 1'b0, 1'b1);
            return 1;
        end
        lag = c.now - c.deadline;
        if (c.deadline != '0 && lag != '0 && !lag[TIME_W-1])
        begin
            first = mk_ack(STAGE_REJECTED, RES_EXPIRED, RSN_EXPIRED, c, 1'b0, 1'b1);
            return 1;
        end
        key  = '{id: c.id, seq: c.seq, nonce: c.nonce};
        seen = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (cache_valid[i] && cache_key[i] == key)
                seen = 1'b1;
        if (seen)
        begin
            first = mk_ack(STAGE_DUPLICATE, RES_ALREADY_DONE, RSN_NONE, c, 1'b0, 1'b1);
            return 1;
        end
        // deploy meaning wins when both ids match
        if (c.id == deploy_id)
        begin
            if (c.param != '0)
            begin
                first = mk_ack(STAGE_REJECTED, RES_BAD_FORMAT, RSN_INHIBITED, c, 1'b0, 1'b1);
                return 1;
            end
            first  = mk_ack(STAGE_ACCEPTED, RES_OK, RSN_NONE, c, 1'b0, 1'b0);
            second = mk_ack(STAGE_EXECUTED, RES_OK, RSN_NONE, c, 1'b1, 1'b1);
        end
        else if (c.id != deprecated_id)
        begin
            first = mk_ack(STAGE_REJECTED, RES_NOT_SUPPORTED, RSN_UNKNOWN, c, 1'b0, 1'b1);
            return 1;
        end
        else
            first = mk_ack(STAGE_REJECTED, RES_NOT_SUPPORTED, RSN_DEPRECATED, c, 1'b0, 1'b1);
        cache_valid[cache_ptr] = 1'b1;
        cache_key[cache_ptr]   = key;
        cache_ptr              = (cache_ptr + 1) % NUM_SLOTS;
        return (c.id == deploy_id) ? 2 : 1;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t        c;
        cmd_key_t    k;
        int unsigned pick;
        c.is_cmd = ($urandom_range(99) >= 8);
        c.auth   = ($urandom_range(99) >= 8);
        pick     = $urandom_range(99);
        if (pick < 40)
            c.id = deploy_id;
        else if (pick < 60)
            c.id = deprecated_id;
        else
            c.id = ID_W'($urandom);
        c.seq   = SEQ_W'($urandom);
        c.nonce = $urandom;
        // replay a recent command now and then
        if (recent_keys.size() != 0 && $urandom_range(99) < 20)
        begin
            k       = recent_keys[$urandom_range(recent_keys.size() - 1)];
            c.id    = k.id;
            c.seq   = k.seq;
            c.nonce = k.nonce;
        end
        c.now = $urandom;
        pick  = $urandom_range(99);
        if (pick < 30)
            c.deadline = '0;
        else if (pick < 65)
            c.deadline = c.now + $urandom_range(5000);
        else if (pick < 80)
            c.deadline = c.now - $urandom_range(5000, 1);
        else
            c.deadline = $urandom;
        c.param = ($urandom_range(99) < 75) ? '0 : PARAM_W'($urandom);
        return c;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
        end
    endtask

    task automatic match_ack();
        ack_exp_t want;
        if (pending_acks.size() == 0)
        begin
            errors++;
            $display("%0t ns: unexpected ack, expected none actual tdata=%h tlast=%b",
                     $time, m_tdata, m_tlast);
            return;
        end
        want = pending_acks.pop_front();
        acks_checked++;
        if (want.fire)
            fires_seen++;
        if (want.stage == STAGE_DUPLICATE)
            dups_seen++;
        check_field("ack_stage",     32'(want.stage),  32'(m_tdata[1:0]));
        check_field("ack_result",    32'(want.result), 32'(m_tdata[4:2]));
        check_field("reject_reason", 32'(want.reason), 32'(m_tdata[7:5]));
        check_field("echo_id",       32'(want.id),     32'(m_tdata[15:8]));
        check_field("echo_seq",      32'(want.seq),    32'(m_tdata[31:16]));
        check_field("echo_nonce",    want.nonce,       m_tdata[63:32]);
        check_field("deploy_fire",   32'(want.fire),   32'(m_tdata[64]));
        check_field("last",          32'(want.is_last), 32'(m_tlast));
    endtask

    // ack side: scoring, random stalls and the long hold-off
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            match_ack();
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_taken)
        begin
            hold_taken <= hold_asks;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= steady || ($urandom_range(99) >= 11);
    end

    // request side; typed_n below zero means the model gives the acks
    task automatic send_command(input cmd_t c, input int typed_n, input ack_exp_t typed_ack);
        ack_exp_t first;
        ack_exp_t second;
        int       n;
        if (!steady && $urandom_range(99) < 11)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, c.param, c.now, c.deadline, c.nonce, c.seq, c.id, c.auth};
        s_tuser  <= c.is_cmd;
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent++;
        n = judge_command(c, first, second);
        if (typed_n >= 0)
        begin
            if (typed_n > 0)
                pending_acks.push_back(typed_ack);
        end
        else
        begin
            if (n > 0)
                pending_acks.push_back(first);
            if (n > 1)
                pending_acks.push_back(second);
        end
        recent_keys.push_back('{id: c.id, seq: c.seq, nonce: c.nonce});
        if (recent_keys.size() > 6)
            void'(recent_keys.pop_front());
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_acks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_ids(input logic [ID_W-1:0] deploy, input logic [ID_W-1:0] deprec);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_DEPLOY_ID;
        cfg_wdata <= deploy;
        @(posedge clk);
        cfg_addr  <= CFG_DEPRECATED_ID;
        cfg_wdata <= deprec;
        @(posedge clk);
        cfg_we        <= 1'b0;
        deploy_id     = deploy;
        deprecated_id = deprec;
        id_settings++;
    endtask

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no request moved for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        cmd_t     c;
        ack_exp_t typed;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
        end
        cache_ptr     = 0;
        deploy_id     = DEPLOY_ID_RST;
        deprecated_id = DEPRECATED_ID_RST;
        steady        = 1'b0;
        hold_asks     = 0;
        hold_taken    = 0;
        hold_left     = 0;
        errors        = 0;
        requests_sent = 0;
        acks_checked  = 0;
        fires_seen    = 0;
        dups_seen     = 0;
        id_settings   = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed[r])
        begin
            typed = mk_ack(directed[r].stage, directed[r].result, directed[r].reason,
                           directed[r].c, 1'b0, 1'b1);
            send_command(directed[r].c, directed[r].typed ? int'(directed[r].n_acks) : -1,
                         typed);
        end
        settle();

        // both registers on one id
        set_ids(8'h80, 8'h80);
        c = '{1'b1, 1'b1, 8'h80, 16'h40, 32'h4040, 32'h0, 32'h0, 16'h0};
        send_command(c, -1, '0);
        c.seq = 16'h41;
        send_command(c, -1, '0);
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       set_ids(8'h00, 8'hFF);
                1:       set_ids(8'hFF, 8'h00);
                2:       set_ids(8'h80, 8'h80);
                3:       set_ids(ID_W'($urandom), ID_W'($urandom));
                default: set_ids(DEPLOY_ID_RST, DEPRECATED_ID_RST);
            endcase
            steady = (p == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 1 && k == 20)
                    hold_asks++;
                if (k == 90)
                    settle();
                send_command(random_cmd(), -1, '0);
            end
            settle();
        end
        steady = 1'b0;

        $display("covered %0d requests and %0d acks: %0d deploy strobes, %0d duplicates",
                 requests_sent, acks_checked, fires_seen, dups_seen);
        $display("over %0d id register settings, one long ack stall and drained pauses",
                 id_settings);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/crg_pkg.sv
rtl/core/crg_replay_cache.sv
rtl/core/command_replay_gate.sv
bench/command_replay_gate_tb.sv
